@@ sv/rpa_pkg.sv @@
// rpa_pkg: shared widths, codes and sequencer states for the page allocator
// used by refcounted_page_allocator; no dependencies
package rpa_pkg;

  localparam int NUM_PAGES_DEF  = 256;
  localparam int REF_BITS_DEF   = 16;
  localparam int NODE_COUNT_DEF = 8;

  localparam int PAGE_W   = 8;
  localparam int NODE_W   = 4;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;

  localparam logic [NODE_W-1:0] NODE_NONE = 4'hF;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RETAIN  = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_BAD_ID    = 3'd1,
    STS_EXHAUSTED = 3'd2,
    STS_RET_FREE  = 3'd3,
    STS_OVERFLOW  = 3'd4,
    STS_DBL_REL   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_LOOK,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_FIN,
    S_OUT
  } state_t;

endpackage

@@ sv/rpa_ram.sv @@
// rpa_ram: single write port, single read port memory with registered read
// no dependencies; used for the free list and the per-page tables
module rpa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/refcounted_page_allocator.sv @@
// refcounted_page_allocator: reference-counted page pool with node preference
// depends on rpa_pkg and rpa_ram
//
// one request per transfer on s_tvalid/s_tready/s_tdata, one result per request
// on m_tvalid/m_tready/m_tdata. the block takes one request at a time: s_tready
// is high only while the sequencer is idle, and the result sits in an output
// register, so the next request is taken while the last result waits.
// retain, release and query pass from dispatch through a table lookup state to output; a bad
// id goes from dispatch straight to output, as does allocate from an empty free list. without a
// node preference allocate pops the newest free list entry. with a preference the free list is
// scanned one entry per cycle for the oldest page on that node, else the newest entry is taken,
// then entries above it are moved down one per cycle through the free list read and write ports.
// reset empties the free list and clears the created page count; the page tables need no
// clearing since only created pages are read. a stalled receiver holds the result and the
// block then waits in its output state.
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int REF_BITS   = rpa_pkg::REF_BITS_DEF,
  parameter int NODE_COUNT = rpa_pkg::NODE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [rpa_pkg::IN_W-1:0]  s_tdata,  // req_type, page_id, node_pref
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [rpa_pkg::OUT_W-1:0] m_tdata   // status, granted_page, ref_count, page_node
);

  import rpa_pkg::*;

  localparam int PW  = $clog2(NUM_PAGES);
  localparam int CW  = $clog2(NUM_PAGES + 1);
  localparam int XW  = ((PW > PAGE_W) ? PW : PAGE_W) + 1;
  localparam int FW  = NODE_W + PW;
  localparam int RXW = (REF_BITS > COUNT_W) ? REF_BITS : COUNT_W;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
  localparam logic [CW-1:0] POOL_SIZE = CW'(NUM_PAGES);

  state_t state, state_next;

  logic [REQ_W-1:0]    req;
  logic [PAGE_W-1:0]   pid;
  logic                pref;
  logic [NODE_W-1:0]   code;

  logic [CW-1:0] fc, fc_next;
  logic [CW-1:0] created, created_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic [CW-1:0] scan_pos, scan_pos_next;
  logic          scan_vld, scan_vld_next;
  logic [CW-1:0] sh_rd, sh_rd_next;
  logic [CW-1:0] sh_wr, sh_wr_next;
  logic          sh_vld, sh_vld_next;
  logic [PW-1:0]     take_id, take_id_next;
  logic [NODE_W-1:0] take_node, take_node_next;

  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [PAGE_W-1:0]   res_page, res_page_next;
  logic [REF_BITS-1:0] res_count, res_count_next;
  logic [NODE_W-1:0]   res_node, res_node_next;

  logic              fm_we;
  logic [PW-1:0]     fm_waddr, fm_raddr;
  logic [FW-1:0]     fm_wdata, fm_rd;
  logic              rt_we, nt_we;
  logic [PW-1:0]     tab_waddr;
  logic [REF_BITS-1:0] rt_wdata, ref_rd;
  logic [NODE_W-1:0]   nt_wdata, node_rd;

  logic [XW-1:0]     pid_x, created_x, take_x;
  logic [PW-1:0]     pid_idx;
  logic              pid_bad;
  logic [CW-1:0]     fc_m1, fc_m2;
  logic [PW-1:0]     fm_id;
  logic [NODE_W-1:0] fm_node;
  logic              in_pref;
  logic              out_load;
  logic [RXW-1:0]    cnt_x;

  assign s_tready  = (state == S_IDLE);
  assign in_pref   = !s_tdata[13] && (7'(s_tdata[13:10]) < 7'(NODE_COUNT));
  assign pid_x     = XW'(pid);
  assign pid_idx   = pid_x[PW-1:0];
  assign created_x = XW'(created);
  assign take_x    = XW'(take_id);
  assign pid_bad   = (pid_x >= created_x);
  assign fc_m1     = fc - CW'(1);
  assign fc_m2     = fc - CW'(2);
  assign fm_id     = fm_rd[PW-1:0];
  assign fm_node   = fm_rd[FW-1:PW];
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);
  assign cnt_x     = RXW'(res_count);

  rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(FW)) u_free (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rd)
  );

  rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(REF_BITS)) u_ref (
    .clk   (clk),
    .we    (rt_we),
    .waddr (tab_waddr),
    .wdata (rt_wdata),
    .raddr (pid_idx),
    .rdata (ref_rd)
  );

  rpa_ram #(.DEPTH(NUM_PAGES), .WIDTH(NODE_W)) u_node (
    .clk   (clk),
    .we    (nt_we),
    .waddr (tab_waddr),
    .wdata (nt_wdata),
    .raddr (pid_idx),
    .rdata (node_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fc       <= '0;
      created  <= '0;
      scan_vld <= 1'b0;
      sh_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fc       <= fc_next;
      created  <= created_next;
      scan_vld <= scan_vld_next;
      sh_vld   <= sh_vld_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req  <= s_tdata[1:0];
      pid  <= s_tdata[9:2];
      pref <= in_pref;
      code <= in_pref ? s_tdata[13:10] : NODE_NONE;
    end
    scan_idx   <= scan_idx_next;
    scan_pos   <= scan_pos_next;
    sh_rd      <= sh_rd_next;
    sh_wr      <= sh_wr_next;
    take_id    <= take_id_next;
    take_node  <= take_node_next;
    res_status <= res_status_next;
    res_page   <= res_page_next;
    res_count  <= res_count_next;
    res_node   <= res_node_next;
    if (out_load) begin
      m_tdata <= {1'b0, res_node, cnt_x[COUNT_W-1:0], res_page, res_status};
    end
  end

  always_comb begin
    state_next      = state;
    fc_next         = fc;
    created_next    = created;
    scan_idx_next   = scan_idx;
    scan_pos_next   = scan_pos;
    scan_vld_next   = scan_vld;
    sh_rd_next      = sh_rd;
    sh_wr_next      = sh_wr;
    sh_vld_next     = sh_vld;
    take_id_next    = take_id;
    take_node_next  = take_node;
    res_status_next = res_status;
    res_page_next   = res_page;
    res_count_next  = res_count;
    res_node_next   = res_node;
    fm_we     = 1'b0;
    fm_waddr  = fc[PW-1:0];
    fm_wdata  = {node_rd, pid_idx};
    fm_raddr  = scan_idx[PW-1:0];
    rt_we     = 1'b0;
    nt_we     = 1'b0;
    tab_waddr = pid_idx;
    rt_wdata  = REF_ONE;
    nt_wdata  = code;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DISP;
        end
      end

      S_DISP: begin
        if (req == REQ_ALLOC) begin
          if (fc == '0) begin
            if (created >= POOL_SIZE) begin
              res_status_next = STS_EXHAUSTED;
              res_page_next   = '0;
              res_count_next  = '0;
              res_node_next   = NODE_NONE;
            end else begin
              tab_waddr       = created[PW-1:0];
              rt_we           = 1'b1;
              nt_we           = 1'b1;
              created_next    = created + CW'(1);
              res_status_next = STS_OK;
              res_page_next   = created_x[PAGE_W-1:0];
              res_count_next  = REF_ONE;
              res_node_next   = code;
            end
            state_next = S_OUT;
          end else if (pref) begin
            scan_idx_next = '0;
            scan_vld_next = 1'b0;
            state_next    = S_SCAN;
          end else begin
            fm_raddr   = fc_m1[PW-1:0];
            state_next = S_POP;
          end
        end else if (pid_bad) begin
          res_status_next = STS_BAD_ID;
          res_page_next   = pid;
          res_count_next  = '0;
          res_node_next   = NODE_NONE;
          state_next      = S_OUT;
        end else begin
          state_next = S_LOOK;
        end
      end

      S_LOOK: begin
        res_page_next   = pid;
        res_node_next   = node_rd;
        res_status_next = STS_OK;
        res_count_next  = ref_rd;
        case (req)
          REQ_RETAIN: begin
            if (ref_rd == '0) begin
              res_status_next = STS_RET_FREE;
            end else if (ref_rd == REF_MAX) begin
              res_status_next = STS_OVERFLOW;
            end else begin
              rt_we          = 1'b1;
              rt_wdata       = ref_rd + REF_ONE;
              res_count_next = ref_rd + REF_ONE;
            end
          end
          REQ_RELEASE: begin
            if (ref_rd == '0) begin
              res_status_next = STS_DBL_REL;
            end else begin
              rt_we          = 1'b1;
              rt_wdata       = ref_rd - REF_ONE;
              res_count_next = ref_rd - REF_ONE;
              if (ref_rd == REF_ONE && fc < POOL_SIZE) begin
                fm_we   = 1'b1;
                fc_next = fc + CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
        state_next = S_OUT;
      end

      S_POP: begin
        take_id_next   = fm_id;
        take_node_next = fm_node;
        state_next     = S_FIN;
      end

      S_SCAN: begin
        if (scan_vld && (fm_node == code || scan_pos == fc_m1)) begin
          take_id_next   = fm_id;
          take_node_next = fm_node;
          scan_vld_next  = 1'b0;
          if (scan_pos == fc_m1) begin
            state_next = S_FIN;
          end else begin
            sh_rd_next  = scan_pos + CW'(1);
            sh_vld_next = 1'b0;
            state_next  = S_SHIFT;
          end
        end else begin
          scan_vld_next = (scan_idx < fc);
          scan_pos_next = scan_idx;
          if (scan_idx < fc) begin
            scan_idx_next = scan_idx + CW'(1);
          end
        end
      end

      S_SHIFT: begin
        fm_raddr = sh_rd[PW-1:0];
        if (sh_vld) begin
          fm_we    = 1'b1;
          fm_waddr = sh_wr[PW-1:0];
          fm_wdata = fm_rd;
        end
        if (sh_vld && sh_wr == fc_m2) begin
          sh_vld_next = 1'b0;
          state_next  = S_FIN;
        end else begin
          sh_vld_next = (sh_rd < fc);
          sh_wr_next  = sh_rd - CW'(1);
          if (sh_rd < fc) begin
            sh_rd_next = sh_rd + CW'(1);
          end
        end
      end

      S_FIN: begin
        fc_next         = fc_m1;
        tab_waddr       = take_id;
        rt_we           = 1'b1;
        nt_we           = pref;
        res_status_next = STS_OK;
        res_page_next   = take_x[PAGE_W-1:0];
        res_count_next  = REF_ONE;
        res_node_next   = pref ? code : take_node;
        state_next      = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ bench/tb_refcounted_page_allocator.sv @@
// tb_refcounted_page_allocator: self-checking bench for the reference-counted page allocator
// drives request transfers, predicts every result and compares it field by field
// depends on rpa_pkg and refcounted_page_allocator
module tb_refcounted_page_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import rpa_pkg::*;

  localparam int POOL_PAGES = NUM_PAGES_DEF;
  localparam int NODE_LIMIT = NODE_COUNT_DEF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'((64'd1 << REF_BITS_DEF) - 1);

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   page;
    logic [COUNT_W-1:0]  count;
    logic [NODE_W-1:0]   node;
  } page_result_t;

  typedef struct {
    req_t               req;
    logic [PAGE_W-1:0]  pid;
    logic [NODE_W-1:0]  node;
    bit                 typed;
    page_result_t       want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;   // req_type, page_id, node_pref
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_W-1:0]    m_tdata;   // status, granted_page, ref_count, page_node

  refcounted_page_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predicted pool state
  logic [PAGE_W-1:0]   pool_free_list [POOL_PAGES];
  int                  pool_free_cnt = 0;
  int                  pool_created_cnt = 0;
  logic [COUNT_W-1:0]  page_refs [POOL_PAGES];
  logic [NODE_W-1:0]   page_nodes [POOL_PAGES];

  page_result_t        pending_results [$];
  int                  mismatches = 0;
  int                  src_idle_pct = 0;
  int                  sink_idle_pct = 0;
  int                  alloc_pct = 40;
  logic                sink_hold = 1'b0;
  bit                  hold_go = 1'b0;

  stim_row_t stim_rows [22] = '{
    '{REQ_QUERY,   8'd0,   NODE_NONE, 1'b1, '{STS_BAD_ID, 8'd0,   16'd0, NODE_NONE}},
    '{REQ_RELEASE, 8'd255, NODE_NONE, 1'b1, '{STS_BAD_ID, 8'd255, 16'd0, NODE_NONE}},
    '{REQ_ALLOC,   8'd0,   NODE_NONE, 1'b1, '{STS_OK,     8'd0,   16'd1, NODE_NONE}},
    '{REQ_ALLOC,   8'd0,   4'd7,      1'b1, '{STS_OK,     8'd1,   16'd1, 4'd7}},
    '{REQ_ALLOC,   8'd0,   4'd0,      1'b1, '{STS_OK,     8'd2,   16'd1, 4'd0}},
    '{REQ_RETAIN,  8'd0,   4'd0,      1'b1, '{STS_OK,     8'd0,   16'd2, NODE_NONE}},
    '{REQ_RELEASE, 8'd0,   4'd0,      1'b0, '0},
    '{REQ_RELEASE, 8'd0,   4'd0,      1'b0, '0},
    '{REQ_RELEASE, 8'd0,   4'd0,      1'b1, '{STS_DBL_REL,  8'd0, 16'd0, NODE_NONE}},
    '{REQ_RETAIN,  8'd0,   4'd0,      1'b1, '{STS_RET_FREE, 8'd0, 16'd0, NODE_NONE}},
    '{REQ_RELEASE, 8'd1,   4'd0,      1'b0, '0},
    '{REQ_RELEASE, 8'd2,   4'd0,      1'b0, '0},
    '{REQ_QUERY,   8'd1,   4'd0,      1'b0, '0},
    '{REQ_ALLOC,   8'd0,   4'd7,      1'b0, '0},
    '{REQ_ALLOC,   8'd0,   4'd3,      1'b0, '0},
    '{REQ_ALLOC,   8'd0,   4'h8,      1'b0, '0},
    '{REQ_RELEASE, 8'd1,   4'd0,      1'b0, '0},
    '{REQ_ALLOC,   8'd0,   NODE_NONE, 1'b0, '0},
    '{REQ_ALLOC,   8'd0,   4'h9,      1'b0, '0},
    '{REQ_QUERY,   8'd3,   4'd5,      1'b0, '0},
    '{REQ_RETAIN,  8'd4,   4'd0,      1'b1, '{STS_BAD_ID, 8'd4,   16'd0, NODE_NONE}},
    '{REQ_QUERY,   8'h80,  4'd0,      1'b1, '{STS_BAD_ID, 8'h80,  16'd0, NODE_NONE}}
  };

  function automatic page_result_t predict_page_request(input req_t req,
                                                         input logic [PAGE_W-1:0] pid,
                                                         input logic [NODE_W-1:0] nd);
    page_result_t res;
    logic pref;
    logic found;
    int pos;
    int i;
    logic [PAGE_W-1:0] id;
    pref = (nd < NODE_LIMIT);
    res = '{STS_OK, pid, '0, NODE_NONE};
    if (req == REQ_ALLOC) begin
      if (pool_free_cnt > 0) begin
        pos = pool_free_cnt - 1;
        found = 1'b0;
        if (pref) begin
          for (i = 0; i < pool_free_cnt; i++) begin
            if (!found && page_nodes[pool_free_list[i]] == nd) begin
              pos = i;
              found = 1'b1;
            end
          end
        end
        id = pool_free_list[pos];
        for (i = pos; i < pool_free_cnt - 1; i++) begin
          pool_free_list[i] = pool_free_list[i+1];
        end
        pool_free_cnt--;
        if (pref) begin
          page_nodes[id] = nd;
        end
        page_refs[id] = 16'd1;
        res = '{STS_OK, id, 16'd1, page_nodes[id]};
      end else if (pool_created_cnt >= POOL_PAGES) begin
        res = '{STS_EXHAUSTED, 8'd0, 16'd0, NODE_NONE};
      end else begin
        id = PAGE_W'(pool_created_cnt);
        pool_created_cnt++;
        page_nodes[id] = pref ? nd : NODE_NONE;
        page_refs[id] = 16'd1;
        res = '{STS_OK, id, 16'd1, page_nodes[id]};
      end
    end else if (pid >= pool_created_cnt) begin
      res = '{STS_BAD_ID, pid, 16'd0, NODE_NONE};
    end else begin
      res.node = page_nodes[pid];
      res.count = page_refs[pid];
      case (req)
        REQ_RETAIN: begin
          if (page_refs[pid] == 0) begin
            res.status = STS_RET_FREE;
          end else if (page_refs[pid] >= COUNT_MAX) begin
            res.status = STS_OVERFLOW;
          end else begin
            page_refs[pid]++;
            res.count = page_refs[pid];
          end
        end
        REQ_RELEASE: begin
          if (page_refs[pid] == 0) begin
            res.status = STS_DBL_REL;
          end else begin
            page_refs[pid]--;
            res.count = page_refs[pid];
            if (page_refs[pid] == 0 && pool_free_cnt < POOL_PAGES) begin
              pool_free_list[pool_free_cnt] = pid;
              pool_free_cnt++;
            end
          end
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got_v, want_v);
    mismatches++;
  endtask

  task automatic issue_request(input req_t req, input logic [PAGE_W-1:0] pid,
                               input logic [NODE_W-1:0] nd, input bit typed,
                               input page_result_t want);
    page_result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, nd, pid, req};
    do @(posedge clk); while (!s_tready);
    pred = predict_page_request(req, pid, nd);
    if (typed) begin
      pred = want;
    end
    pending_results = {pending_results, pred};
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    int k;
    k = $urandom_range(9);
    if (k < 6) begin
      return NODE_W'($urandom_range(NODE_LIMIT - 1));
    end else if (k < 8) begin
      return NODE_NONE;
    end
    return NODE_W'($urandom_range(15));
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page(input bit live);
    int p;
    int tries;
    if (pool_created_cnt == 0 || $urandom_range(15) == 0) begin
      return PAGE_W'($urandom_range(255));
    end
    p = $urandom_range(pool_created_cnt - 1);
    for (tries = 0; live && tries < 6 && page_refs[p] == 0; tries++) begin
      p = $urandom_range(pool_created_cnt - 1);
    end
    return PAGE_W'(p);
  endfunction

  task automatic issue_random();
    req_t req;
    int sel;
    int k;
    sel = $urandom_range(99);
    k = $urandom_range(99);
    if (sel < alloc_pct) begin
      req = REQ_ALLOC;
    end else if (k < 40) begin
      req = REQ_RETAIN;
    end else if (k < 85) begin
      req = REQ_RELEASE;
    end else begin
      req = REQ_QUERY;
    end
    issue_request(req, pick_page(req != REQ_QUERY), pick_node(), 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (hold_go);
    repeat (20) @(posedge clk);
    sink_hold <= 1'b1;
    repeat (600) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    page_result_t got;
    page_result_t want;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tdata[2:0]);
        got.page   = m_tdata[10:3];
        got.count  = m_tdata[26:11];
        got.node   = m_tdata[30:27];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result transfer", m_tdata, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.page != want.page) report_mismatch("granted_page", got.page, want.page);
          if (got.count != want.count) report_mismatch("ref_count", got.count, want.count);
          if (got.node != want.node) report_mismatch("page_node", got.node, want.node);
        end
      end
      m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      issue_request(stim_rows[i].req, stim_rows[i].pid, stim_rows[i].node,
                    stim_rows[i].typed, stim_rows[i].want);
    end

    src_idle_pct  = 9;
    sink_idle_pct = 69;
    alloc_pct     = 45;
    repeat (300) issue_random();

    src_idle_pct  = 69;
    sink_idle_pct = 9;
    while (pool_created_cnt < POOL_PAGES || pool_free_cnt != 0) begin
      issue_request(REQ_ALLOC, 8'd0, pick_node(), 1'b0, '0);
    end
    repeat (3) begin
      issue_request(REQ_ALLOC, 8'd0, pick_node(), 1'b1,
                    '{STS_EXHAUSTED, 8'd0, 16'd0, NODE_NONE});
    end
    issue_request(REQ_QUERY, 8'd255, 4'd0, 1'b0, '0);
    alloc_pct = 25;
    repeat (300) issue_random();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    alloc_pct     = 40;
    hold_go       = 1'b1;
    repeat (300) issue_random();
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ refcounted_page_allocator.f @@
sv/rpa_pkg.sv
sv/rpa_ram.sv
sv/refcounted_page_allocator.sv
bench/tb_refcounted_page_allocator.sv
